// ===== hdl/wpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsp_pkg
// types and constants for the riff/wave pcm16 byte stream parser
// ----------------------------------------------------------------------------
package wpsp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } wpsp_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic [3:0]         error_code;
    logic [1:0]         channel_count;
    logic               last_of_run;
  } wpsp_out_t;

  typedef enum logic [4:0] {
    PH_FILE_HDR  = 5'b00001,
    PH_CHUNK_HDR = 5'b00010,
    PH_BODY      = 5'b00100,
    PH_PAD       = 5'b01000,
    PH_DEAD      = 5'b10000
  } wpsp_phase_t;

  localparam logic [1:0] CK_OTHER    = 2'd0;
  localparam logic [1:0] CK_FMT      = 2'd1;
  localparam logic [1:0] CK_DATA     = 2'd2;
  localparam logic [1:0] CK_REJECTED = 2'd3;

  localparam logic [3:0] ERR_OK         = 4'd0;
  localparam logic [3:0] ERR_NOT_WAVE   = 4'd1;
  localparam logic [3:0] ERR_SIZE       = 4'd2;
  localparam logic [3:0] ERR_TRUNC_HDR  = 4'd3;
  localparam logic [3:0] ERR_OVERRUN    = 4'd4;
  localparam logic [3:0] ERR_BAD_FMT    = 4'd5;
  localparam logic [3:0] ERR_SECOND_DAT = 4'd6;
  localparam logic [3:0] ERR_NO_PAD     = 4'd7;
  localparam logic [3:0] ERR_MISSING    = 4'd8;
  localparam logic [3:0] ERR_ENCODING   = 4'd9;
  localparam logic [3:0] ERR_ALIGN      = 4'd10;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_LEN  = 32'd16;
  localparam logic [31:0] RATE_RESET = 32'd48000;
  localparam logic [15:0] PCM_DEPTH  = 16'd16;

endpackage

// ===== hdl/wav_pcm16_stream_parser.sv =====
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser
// parses a riff/wave file byte by byte, streams pcm16 samples and a verdict
// ----------------------------------------------------------------------------
// results are registered: each goes into the result queue on the beat that causes it
// throughput: one byte per cycle; a beat queues up to two results (a sample
//   and the verdict), drained one per cycle while out_stall is low through a
//   four-entry result queue; the input stalls while more than two results wait
// reset: rst clears all parse state, the queue, and sets the rate to 48000
module wav_pcm16_stream_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wpsp_pkg::wpsp_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wpsp_pkg::wpsp_out_t  out_data,
  input  logic                 cfg_write,
  input  logic [31:0]          cfg_data
);
  import wpsp_pkg::*;

  logic [31:0] required_sample_rate;
  logic [32:0] file_offset, file_offset_next;
  logic [31:0] declared_size, declared_size_next;
  wpsp_phase_t parse_phase, parse_phase_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [1:0]  chunk_kind, chunk_kind_next;
  logic        have_format, have_format_next;
  logic        have_audio, have_audio_next;
  logic [15:0] format_tag, format_tag_next;
  logic [15:0] channel_field, channel_field_next;
  logic [31:0] rate_field, rate_field_next;
  logic [31:0] byte_rate_field, byte_rate_field_next;
  logic [15:0] align_field, align_field_next;
  logic [15:0] depth_field, depth_field_next;
  logic [31:0] audio_length, audio_length_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [3:0]  first_error, first_error_next;

  logic        accept, pop;
  logic [7:0]  b;
  logic [2:0]  c;
  logic [31:0] body_idx;
  logic        do_end;
  logic        emit_sample;
  logic [15:0] sample_word;
  logic [3:0]  err;
  logic [31:0] byte_rate_exp;
  logic        misaligned;
  wpsp_out_t   res_sample, res_verdict;

  wpsp_out_t   queue [4];
  logic [2:0]  wr_ptr, rd_ptr, count;
  logic [1:0]  wr_a, wr_b;

  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (count > 3'd2);
  assign out_valid = (count != 3'd0);
  assign b         = in_data.byte_value;
  assign c         = chunk_remaining[2:0];
  assign body_idx  = chunk_length - chunk_remaining;

  always_comb begin
    file_offset_next     = (file_offset != '1) ? file_offset + 33'd1 : file_offset;
    declared_size_next   = declared_size;
    parse_phase_next     = parse_phase;
    tag_shift_next       = tag_shift;
    chunk_length_next    = chunk_length;
    chunk_remaining_next = chunk_remaining;
    chunk_kind_next      = chunk_kind;
    have_format_next     = have_format;
    have_audio_next      = have_audio;
    format_tag_next      = format_tag;
    channel_field_next   = channel_field;
    rate_field_next      = rate_field;
    byte_rate_field_next = byte_rate_field;
    align_field_next     = align_field;
    depth_field_next     = depth_field;
    audio_length_next    = audio_length;
    low_byte_hold_next   = low_byte_hold;
    first_error_next     = first_error;
    do_end               = 1'b0;
    emit_sample          = 1'b0;
    sample_word          = {b, low_byte_hold};

    unique case (parse_phase)
      PH_FILE_HDR: begin
        if (file_offset < 33'd4 || file_offset >= 33'd8) begin
          tag_shift_next = {tag_shift[23:0], b};
        end else begin
          case (file_offset[1:0])
            2'd0: declared_size_next[7:0]   = declared_size[7:0] | b;
            2'd1: declared_size_next[15:8]  = declared_size[15:8] | b;
            2'd2: declared_size_next[23:16] = declared_size[23:16] | b;
            default: declared_size_next[31:24] = declared_size[31:24] | b;
          endcase
        end
        if (file_offset == 33'd3 && tag_shift_next != TAG_RIFF) begin
          first_error_next = ERR_NOT_WAVE;
          parse_phase_next = PH_DEAD;
        end else if (file_offset == 33'd11) begin
          if (tag_shift_next != TAG_WAVE) begin
            first_error_next = ERR_NOT_WAVE;
            parse_phase_next = PH_DEAD;
          end else begin
            parse_phase_next     = PH_CHUNK_HDR;
            chunk_remaining_next = '0;
          end
        end
      end
      PH_CHUNK_HDR: begin
        if (c == 3'd0) chunk_length_next = '0;
        if (c < 3'd4) begin
          tag_shift_next = {tag_shift[23:0], b};
        end else begin
          case (c[1:0])
            2'd0: chunk_length_next[7:0]   = b;
            2'd1: chunk_length_next[15:8]  = chunk_length[15:8] | b;
            2'd2: chunk_length_next[23:16] = chunk_length[23:16] | b;
            default: chunk_length_next[31:24] = chunk_length[31:24] | b;
          endcase
        end
        chunk_remaining_next = {29'd0, c} + 32'd1;
        if (c == 3'd7) begin
          if (tag_shift == TAG_FMT) begin
            if (have_format || chunk_length_next != FMT_LEN) begin
              chunk_kind_next = CK_REJECTED;
            end else begin
              chunk_kind_next  = CK_FMT;
              have_format_next = 1'b1;
            end
          end else if (tag_shift == TAG_DATA) begin
            if (have_audio) begin
              chunk_kind_next = CK_REJECTED;
            end else begin
              chunk_kind_next   = CK_DATA;
              have_audio_next   = 1'b1;
              audio_length_next = chunk_length_next;
            end
          end else begin
            chunk_kind_next = CK_OTHER;
          end
          chunk_remaining_next = chunk_length_next;
          parse_phase_next     = PH_BODY;
          do_end               = (chunk_length_next == '0);
        end
      end
      PH_BODY: begin
        if (chunk_kind == CK_FMT && body_idx[31:4] == '0) begin
          case (body_idx[3:0])
            4'd0:  format_tag_next[7:0]       = format_tag[7:0] | b;
            4'd1:  format_tag_next[15:8]      = format_tag[15:8] | b;
            4'd2:  channel_field_next[7:0]    = channel_field[7:0] | b;
            4'd3:  channel_field_next[15:8]   = channel_field[15:8] | b;
            4'd4:  rate_field_next[7:0]       = rate_field[7:0] | b;
            4'd5:  rate_field_next[15:8]      = rate_field[15:8] | b;
            4'd6:  rate_field_next[23:16]     = rate_field[23:16] | b;
            4'd7:  rate_field_next[31:24]     = rate_field[31:24] | b;
            4'd8:  byte_rate_field_next[7:0]  = byte_rate_field[7:0] | b;
            4'd9:  byte_rate_field_next[15:8] = byte_rate_field[15:8] | b;
            4'd10: byte_rate_field_next[23:16] = byte_rate_field[23:16] | b;
            4'd11: byte_rate_field_next[31:24] = byte_rate_field[31:24] | b;
            4'd12: align_field_next[7:0]      = align_field[7:0] | b;
            4'd13: align_field_next[15:8]     = align_field[15:8] | b;
            4'd14: depth_field_next[7:0]      = depth_field[7:0] | b;
            default: depth_field_next[15:8]   = depth_field[15:8] | b;
          endcase
        end else if (chunk_kind == CK_DATA) begin
          if (!body_idx[0]) low_byte_hold_next = b;
          else emit_sample = 1'b1;
        end
        chunk_remaining_next = chunk_remaining - 32'd1;
        do_end               = (chunk_remaining_next == '0);
      end
      PH_PAD: begin
        parse_phase_next     = PH_CHUNK_HDR;
        chunk_remaining_next = '0;
      end
      PH_DEAD: begin
      end
      default: begin
      end
    endcase

    // end of chunk body
    if (do_end) begin
      if (chunk_kind_next == CK_REJECTED) begin
        first_error_next = (tag_shift_next == TAG_FMT) ? ERR_BAD_FMT : ERR_SECOND_DAT;
        parse_phase_next = PH_DEAD;
      end else if (chunk_length_next[0]) begin
        parse_phase_next = PH_PAD;
      end else begin
        parse_phase_next     = PH_CHUNK_HDR;
        chunk_remaining_next = '0;
      end
    end
  end

  // verdict, only meaningful on the final byte; align is 2 or 4 once it matters
  always_comb begin
    byte_rate_exp = align_field_next[2] ? {rate_field_next[29:0], 2'b00}
                                        : {rate_field_next[30:0], 1'b0};
    misaligned    = align_field_next[2] ? (audio_length_next[1:0] != 2'b00)
                                        : audio_length_next[0];
    if (first_error_next == ERR_NOT_WAVE || file_offset < 33'd11) begin
      err = ERR_NOT_WAVE;
    end else if ({2'b00, declared_size_next} + 34'd8 != {1'b0, file_offset} + 34'd1) begin
      err = ERR_SIZE;
    end else if (first_error_next != ERR_OK) begin
      err = first_error_next;
    end else if (parse_phase_next == PH_CHUNK_HDR && chunk_remaining_next != '0) begin
      err = ERR_TRUNC_HDR;
    end else if (parse_phase_next == PH_BODY) begin
      err = ERR_OVERRUN;
    end else if (parse_phase_next == PH_PAD) begin
      err = ERR_NO_PAD;
    end else if (!have_format_next || !have_audio_next) begin
      err = ERR_MISSING;
    end else if (format_tag_next != 16'd1 ||
                 (channel_field_next != 16'd1 && channel_field_next != 16'd2) ||
                 rate_field_next != required_sample_rate ||
                 depth_field_next != PCM_DEPTH ||
                 align_field_next != {channel_field_next[14:0], 1'b0} ||
                 byte_rate_field_next != byte_rate_exp) begin
      err = ERR_ENCODING;
    end else if (misaligned) begin
      err = ERR_ALIGN;
    end else begin
      err = ERR_OK;
    end

    res_sample.kind          = 1'b0;
    res_sample.sample        = sample_word;
    res_sample.error_code    = ERR_OK;
    res_sample.channel_count = 2'd0;
    res_sample.last_of_run   = !in_data.end_of_file;

    res_verdict.kind          = 1'b1;
    res_verdict.sample        = '0;
    res_verdict.error_code    = err;
    res_verdict.channel_count = (err == ERR_OK) ? channel_field_next[1:0] : 2'd0;
    res_verdict.last_of_run   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      required_sample_rate <= RATE_RESET;
    end else if (cfg_write) begin
      required_sample_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.end_of_file)) begin
      file_offset     <= '0;
      declared_size   <= '0;
      parse_phase     <= PH_FILE_HDR;
      tag_shift       <= '0;
      chunk_length    <= '0;
      chunk_remaining <= '0;
      chunk_kind      <= CK_OTHER;
      have_format     <= 1'b0;
      have_audio      <= 1'b0;
      format_tag      <= '0;
      channel_field   <= '0;
      rate_field      <= '0;
      byte_rate_field <= '0;
      align_field     <= '0;
      depth_field     <= '0;
      audio_length    <= '0;
      low_byte_hold   <= '0;
      first_error     <= ERR_OK;
    end else if (accept) begin
      file_offset     <= file_offset_next;
      declared_size   <= declared_size_next;
      parse_phase     <= parse_phase_next;
      tag_shift       <= tag_shift_next;
      chunk_length    <= chunk_length_next;
      chunk_remaining <= chunk_remaining_next;
      chunk_kind      <= chunk_kind_next;
      have_format     <= have_format_next;
      have_audio      <= have_audio_next;
      format_tag      <= format_tag_next;
      channel_field   <= channel_field_next;
      rate_field      <= rate_field_next;
      byte_rate_field <= byte_rate_field_next;
      align_field     <= align_field_next;
      depth_field     <= depth_field_next;
      audio_length    <= audio_length_next;
      low_byte_hold   <= low_byte_hold_next;
      first_error     <= first_error_next;
    end
  end

  // result queue: up to two entries written per beat, one read
  assign wr_a = wr_ptr[1:0];
  assign wr_b = emit_sample ? wr_ptr[1:0] + 2'd1 : wr_ptr[1:0];

  always_ff @(posedge clk) begin
    if (accept && emit_sample) queue[wr_a] <= res_sample;
    if (accept && in_data.end_of_file) queue[wr_b] <= res_verdict;
  end

  assign out_data = queue[rd_ptr[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + (accept ? {2'b00, emit_sample} + {2'b00, in_data.end_of_file} : 3'd0);
      rd_ptr <= rd_ptr + {2'b00, pop};
      count  <= count + (accept ? {2'b00, emit_sample} + {2'b00, in_data.end_of_file} : 3'd0)
                - {2'b00, pop};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("result queue overflow");
  a_eof_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.end_of_file) |=> out_valid)
    else $error("no verdict queued after final byte");
  a_eof_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.end_of_file) |=>
      (parse_phase == PH_FILE_HDR && file_offset == '0 && first_error == ERR_OK))
    else $error("parser not restarted after final byte");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    count == (wr_ptr - rd_ptr))
    else $error("queue count out of step with pointers");
`endif

endmodule

// ===== tb/sv/tb_wav_pcm16_stream_parser.sv =====
// ----------------------------------------------------------------------------
// tb_wav_pcm16_stream_parser
// drives riff/wave files and short broken headers byte by byte into the parser,
// predicts every sample and verdict, and checks them in order under random gaps and stalls
// ----------------------------------------------------------------------------
module tb_wav_pcm16_stream_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import wpsp_pkg::*;

  localparam int PHASE_HDR   = 0;
  localparam int PHASE_CHDR  = 1;
  localparam int PHASE_BODY  = 2;
  localparam int PHASE_PAD   = 3;
  localparam int PHASE_DEAD  = 4;
  localparam longint OFS_SAT = 64'h1_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  wpsp_in_t in_data;
  logic out_valid;
  logic out_stall;
  wpsp_out_t out_data;
  logic cfg_write;
  logic [31:0] cfg_data;

  wav_pcm16_stream_parser i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  // predicted parser state
  logic [31:0] rate_reg;
  longint unsigned p_ofs;
  logic [31:0] p_size, p_tag, p_clen, p_crem, p_alen;
  int p_phase;
  logic [1:0] p_kind;
  bit p_hfmt, p_hdat;
  logic [15:0] p_ftag, p_chan, p_align, p_depth;
  logic [31:0] p_rate, p_brate;
  logic [7:0] p_low;
  logic [3:0] p_err;

  wpsp_out_t expected_results[$];
  int failures = 0;
  longint cycles = 0;
  bit long_hold = 0;

  // file under construction
  logic [7:0] file_bytes[$];

  function automatic void add_byte(logic [7:0] v);
    file_bytes.insert(file_bytes.size(), v);
  endfunction

  function automatic void add_result(wpsp_out_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void clear_parse();
    p_ofs = 0; p_size = 0; p_phase = PHASE_HDR; p_tag = 0; p_clen = 0;
    p_crem = 0; p_kind = CK_OTHER; p_hfmt = 0; p_hdat = 0; p_ftag = 0;
    p_chan = 0; p_rate = 0; p_brate = 0; p_align = 0; p_depth = 0;
    p_alen = 0; p_low = 0; p_err = ERR_OK;
  endfunction

  function automatic void close_body();
    if (p_kind == CK_REJECTED) begin
      p_err = (p_tag == TAG_FMT) ? ERR_BAD_FMT : ERR_SECOND_DAT;
      p_phase = PHASE_DEAD;
    end else if (p_clen[0]) begin
      p_phase = PHASE_PAD;
    end else begin
      p_phase = PHASE_CHDR;
      p_crem = 0;
    end
  endfunction

  function automatic logic [3:0] judge(longint unsigned ofs, output logic [1:0] ch);
    logic [31:0] prod;
    ch = '0;
    if (p_err == ERR_NOT_WAVE || ofs < 11) return ERR_NOT_WAVE;
    if ({32'd0, p_size} + 8 != ofs + 1) return ERR_SIZE;
    if (p_err != ERR_OK) return p_err;
    if (p_phase == PHASE_CHDR && p_crem != 0) return ERR_TRUNC_HDR;
    if (p_phase == PHASE_BODY) return ERR_OVERRUN;
    if (p_phase == PHASE_PAD) return ERR_NO_PAD;
    if (!p_hfmt || !p_hdat) return ERR_MISSING;
    prod = p_rate * {16'd0, p_align};
    if (p_ftag != 1 || (p_chan != 1 && p_chan != 2) || p_rate != rate_reg ||
        p_depth != PCM_DEPTH || p_align != p_chan * 2 || p_brate != prod)
      return ERR_ENCODING;
    if (p_alen % p_align != 0) return ERR_ALIGN;
    ch = p_chan[1:0];
    return ERR_OK;
  endfunction

  function automatic void predict_byte(logic [7:0] b, bit eof);
    longint unsigned ofs;
    logic [31:0] c, i;
    logic [1:0] ch;
    wpsp_out_t r;
    ofs = p_ofs;
    if (p_ofs < OFS_SAT) p_ofs++;
    case (p_phase)
      PHASE_HDR: begin
        if (ofs < 4 || ofs >= 8) p_tag = {p_tag[23:0], b};
        else p_size[(ofs - 4) * 8 +: 8] = b;
        if (ofs == 3 && p_tag != TAG_RIFF) begin
          p_err = ERR_NOT_WAVE; p_phase = PHASE_DEAD;
        end else if (ofs == 11) begin
          if (p_tag != TAG_WAVE) begin
            p_err = ERR_NOT_WAVE; p_phase = PHASE_DEAD;
          end else begin
            p_phase = PHASE_CHDR; p_crem = 0;
          end
        end
      end
      PHASE_CHDR: begin
        c = p_crem & 7;
        if (c == 0) p_clen = 0;
        if (c < 4) p_tag = {p_tag[23:0], b};
        else p_clen[(c - 4) * 8 +: 8] = b;
        p_crem = c + 1;
        if (c == 7) begin
          if (p_tag == TAG_FMT) begin
            if (p_hfmt || p_clen != FMT_LEN) p_kind = CK_REJECTED;
            else begin p_kind = CK_FMT; p_hfmt = 1; end
          end else if (p_tag == TAG_DATA) begin
            if (p_hdat) p_kind = CK_REJECTED;
            else begin p_kind = CK_DATA; p_hdat = 1; p_alen = p_clen; end
          end else begin
            p_kind = CK_OTHER;
          end
          p_crem = p_clen;
          p_phase = PHASE_BODY;
          if (p_crem == 0) close_body();
        end
      end
      PHASE_BODY: begin
        i = p_clen - p_crem;
        if (p_kind == CK_FMT) begin
          if (i < 2) p_ftag[i[0] * 8 +: 8] = b;
          else if (i < 4) p_chan[i[0] * 8 +: 8] = b;
          else if (i < 8) p_rate[i[1:0] * 8 +: 8] = b;
          else if (i < 12) p_brate[i[1:0] * 8 +: 8] = b;
          else if (i < 14) p_align[i[0] * 8 +: 8] = b;
          else if (i < 16) p_depth[i[0] * 8 +: 8] = b;
        end else if (p_kind == CK_DATA) begin
          if (!i[0]) p_low = b;
          else begin
            r = '0;
            r.sample = {b, p_low};
            r.last_of_run = !eof;
            add_result(r);
          end
        end
        p_crem--;
        if (p_crem == 0) close_body();
      end
      PHASE_PAD: begin
        p_phase = PHASE_CHDR; p_crem = 0;
      end
      default: ;
    endcase
    if (eof) begin
      r = '0;
      r.kind = 1'b1;
      r.error_code = judge(ofs, ch);
      r.channel_count = ch;
      r.last_of_run = 1'b1;
      add_result(r);
      clear_parse();
    end
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- result side ----------------
  always @(posedge clk) begin
    wpsp_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d code=%0d", out_data.kind, out_data.error_code);
        failures++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_data.kind); failures++;
        end
        if (out_data.sample !== e.sample) begin
          $error("sample exp %0d got %0d", e.sample, out_data.sample); failures++;
        end
        if (out_data.error_code !== e.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, out_data.error_code);
          failures++;
        end
        if (out_data.channel_count !== e.channel_count) begin
          $error("channel_count exp %0d got %0d", e.channel_count, out_data.channel_count);
          failures++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, out_data.last_of_run);
          failures++;
        end
      end
    end
  end

  // receiver stalls, with one long hold-off while the sender keeps going
  initial begin
    int hold;
    out_stall = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        for (hold = 0; hold < 60; hold++) @(negedge clk);
        long_hold = 0;
      end
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) hold = 0;
      out_stall <= (hold != 0);
      if (hold == 0) @(negedge clk);
      else repeat (hold) @(negedge clk);
      out_stall <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // ---------------- stimulus ----------------
  bit quiet_mode = 0;

  task automatic send_byte(logic [7:0] b, bit eof);
    int gap;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 2);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{byte_value: b, end_of_file: eof};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, eof);
    @(negedge clk);
  endtask

  task automatic send_file();
    int k;
    for (k = 0; k < file_bytes.size(); k++)
      send_byte(file_bytes[k], k == file_bytes.size() - 1);
    in_valid <= 0;
    file_bytes.delete();
    @(negedge clk);
  endtask

  task automatic put32(logic [31:0] v);
    for (int k = 0; k < 4; k++) add_byte(v[k * 8 +: 8]);
  endtask

  task automatic put_tag(logic [31:0] t);
    for (int k = 3; k >= 0; k--) add_byte(t[k * 8 +: 8]);
  endtask

  task automatic put_fmt(logic [15:0] ftag, logic [15:0] ch, logic [31:0] rate,
                         logic [31:0] brate, logic [15:0] al, logic [15:0] dep);
    put_tag(TAG_FMT); put32(FMT_LEN);
    add_byte(ftag[7:0]); add_byte(ftag[15:8]);
    add_byte(ch[7:0]); add_byte(ch[15:8]);
    put32(rate); put32(brate);
    add_byte(al[7:0]); add_byte(al[15:8]);
    add_byte(dep[7:0]); add_byte(dep[15:8]);
  endtask

  // set the riff size field from the byte count, offset by delta
  task automatic seal_size(int delta);
    logic [31:0] s;
    s = 32'(file_bytes.size() - 8 + delta);
    for (int k = 0; k < 4; k++) file_bytes[4 + k] = s[k * 8 +: 8];
  endtask

  // random file: well-formed, or with one fault chosen by mode
  task automatic build_random_file(logic [31:0] rate);
    int nch, dlen, al, mode;
    nch = $urandom_range(1, 2);
    al = nch * 2;
    mode = $urandom_range(0, 19);
    put_tag(TAG_RIFF); put32(32'd0); put_tag(TAG_WAVE);
    if ($urandom_range(0, 3) == 0) begin
      put_tag($urandom); dlen = $urandom_range(0, 5); put32(dlen);
      repeat (dlen) add_byte(8'($urandom));
      if (dlen % 2) add_byte(8'd0);
    end
    if (mode != 1)
      put_fmt(16'((mode == 2) ? $urandom_range(0, 3) : 1),
              16'((mode == 3) ? $urandom_range(0, 3) : nch),
              (mode == 4) ? $urandom : rate, rate * al, 16'(al),
              16'((mode == 5) ? 8 : 16));
    if (mode == 6) begin put_tag(TAG_FMT); put32(32'd16); repeat (16) add_byte(8'd0); end
    if (mode == 7) begin put_tag(TAG_FMT); put32(32'd14); repeat (14) add_byte(8'd0); end
    if (mode != 8) begin
      dlen = $urandom_range(0, 12) * al + ((mode == 9) ? $urandom_range(1, 3) : 0);
      put_tag(TAG_DATA); put32(dlen);
      repeat (dlen) add_byte(8'($urandom));
      if (dlen % 2) add_byte(8'($urandom));
    end
    if (mode == 10) begin put_tag(TAG_DATA); put32(32'd2); add_byte(8'd1);
      add_byte(8'd2); end
    if (mode == 11) begin put_tag(TAG_DATA); put32(32'd4); add_byte(8'd7); end
    if (mode == 12) begin put_tag(TAG_DATA); add_byte(8'd1); end
    if (mode == 13) begin put_tag(TAG_DATA); put32(32'd3); repeat (3) add_byte(8'd9); end
    seal_size((mode == 14) ? $urandom_range(1, 4) : 0);
    if (mode == 15) file_bytes[$urandom_range(0, 11)] = 8'($urandom);
    if (mode == 16) begin
      dlen = $urandom_range(1, 10);
      repeat (dlen) add_byte(8'($urandom));
    end
  endtask

  task automatic wait_drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_rate(logic [31:0] v);
    cfg_write <= 1; cfg_data <= v;
    @(negedge clk);
    cfg_write <= 0;
    rate_reg = v;
  endtask

  // directed rows: byte, end flag, and on final bytes the verdict code
  typedef struct {
    logic [7:0] b;
    bit eof;
    logic [3:0] code;
  } row_t;

  initial begin
    row_t dir_rows[11];
    int fcount, k;
    logic [31:0] rates[4];
    in_valid = 0; in_data = '0; cfg_write = 0; cfg_data = 0;
    rst = 1;
    rate_reg = RATE_RESET;
    clear_parse();
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // short directed stretch: lone bytes and short broken headers
    dir_rows = '{
      '{8'h00, 1'b1, ERR_NOT_WAVE},
      '{8'hFF, 1'b1, ERR_NOT_WAVE},
      '{8'h52, 1'b0, ERR_OK}, '{8'h49, 1'b0, ERR_OK},
      '{8'h46, 1'b0, ERR_OK}, '{8'h46, 1'b1, ERR_NOT_WAVE},
      '{8'h52, 1'b0, ERR_OK}, '{8'h00, 1'b0, ERR_OK},
      '{8'h46, 1'b0, ERR_OK}, '{8'h46, 1'b0, ERR_OK},
      '{8'hAA, 1'b1, ERR_NOT_WAVE}
    };
    for (k = 0; k < 11; k++) begin
      send_byte(dir_rows[k].b, dir_rows[k].eof);
      if (dir_rows[k].eof && expected_results[$].error_code !== dir_rows[k].code) begin
        $error("error_code exp %0d got %0d", dir_rows[k].code,
               expected_results[$].error_code);
        failures++;
      end
    end
    in_valid <= 0;
    @(negedge clk);

    // good stereo file at reset rate, with an odd unknown chunk ahead
    put_tag(TAG_RIFF); put32(32'd0); put_tag(TAG_WAVE);
    put_tag(32'h4C495354); put32(32'd3); repeat (3) add_byte(8'h55);
    add_byte(8'h00);
    put_fmt(16'd1, 16'd2, RATE_RESET, RATE_RESET * 4, 16'd4, PCM_DEPTH);
    put_tag(TAG_DATA); put32(32'd8);
    add_byte(8'h00); add_byte(8'h80);
    add_byte(8'hFF); add_byte(8'h7F);
    add_byte(8'hFF); add_byte(8'hFF);
    add_byte(8'h01); add_byte(8'h00);
    seal_size(0);
    send_file();
    wait_drain();

    rates[0] = 32'd0; rates[1] = 32'hFFFF_FFFF; rates[2] = 32'd44100; rates[3] = RATE_RESET;
    fcount = 0;
    for (k = 0; k < 4; k++) begin
      write_rate(rates[k]);
      repeat (4) begin
        if (k == 1 && fcount == 5) long_hold = 1;
        build_random_file(($urandom_range(0, 4) == 0) ? $urandom : rates[k]);
        quiet_mode = (k == 1 && fcount == 5);
        send_file();
        quiet_mode = 0;
        fcount++;
      end
      wait_drain();
    end
    wait_drain();
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
